### design/cpsd_pkg.sv
// ----------------------------------------------------------------------------
// cpsd_pkg
// shared constants, types and bit-mapping functions of the coil pulse driver
// ----------------------------------------------------------------------------
`default_nettype none

package cpsd_pkg;

    localparam int NUM_DEVICES = 4;
    localparam int DEV_W       = 2;
    localparam int PORT_W      = 8;
    localparam int TICK_W      = 8;
    localparam int POS_W       = 2;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 8;

    localparam logic             OP_CMD  = 1'b0;
    localparam logic             OP_TICK = 1'b1;

    localparam logic             MODE_SWITCH = 1'b0;
    localparam logic             MODE_RELAY  = 1'b1;

    localparam logic [POS_W-1:0] POS_UNKNOWN = 2'd2;

    localparam logic [PORT_W-1:0] TOP_BIT = 8'h80;
    localparam logic [PORT_W-1:0] LOW_BIT = 8'h01;

    localparam logic [CFG_IDX_W-1:0] REG_HOLD0       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD1       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD2       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD3       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ALWAYS_FIRE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BOARD_MODE  = 3'd5;

    typedef logic [PORT_W-1:0] port_t;
    typedef logic [TICK_W-1:0] ticks_t;
    typedef logic [POS_W-1:0]  pos_t;

    typedef struct packed {
        port_t coil_outputs;
        logic  activity_pulse;
    } result_t;

    // both coil bits of a device in the given board mode
    function automatic port_t pair_mask(input logic mode, input logic [DEV_W-1:0] dev);
        logic [3:0] sh;
        sh = {1'b0, dev, 1'b0};
        if (mode == MODE_SWITCH)
        begin
            return (TOP_BIT >> sh) | (TOP_BIT >> (sh + 4'd1));
        end
        return (LOW_BIT << sh) | (LOW_BIT << (sh + 4'd1));
    endfunction

    // bit of one coil of a device in the given board mode
    function automatic port_t coil_bit(input logic mode, input logic [DEV_W-1:0] dev,
                                       input logic gate);
        logic [3:0] sh;
        sh = {1'b0, dev, 1'b0};
        if (mode == MODE_SWITCH)
        begin
            return TOP_BIT >> (sh + {3'd0, gate});
        end
        return LOW_BIT << (sh + 4'd1 - {3'd0, gate});
    endfunction

endpackage

`default_nettype wire

### design/coil_pulse_switch_driver_top.sv
// ----------------------------------------------------------------------------
// coil_pulse_switch_driver_top
// timed pulse driver for four two-coil devices sharing one 8-bit port
// ----------------------------------------------------------------------------
// usage:
//   input channel (in_valid/in_stall) carries either a command (op = 0) with
//   device_index, coil_select and activate, or a 20 ms tick (op = 1).
//   every accepted item yields exactly one result on the output channel
//   (out_valid/out_stall): the port image after the item and activity_pulse,
//   set when a command fired a coil.
//   results are registered: one is valid in the cycle after its transfer
//   when the output register is free. throughput is one item per cycle
//   while in_stall is low; all four countdowns update in parallel per item.
//   an output register plus one skid register absorb a stalled receiver;
//   in_stall rises only once both hold a result, so one more item is taken
//   while the receiver stalls. configuration (cfg_wr_en/cfg_index/cfg_data)
//   is for the user to write only while idle; the block does not enforce it.
//   reset clears hold times, mode bits, countdowns and the port image, sets
//   every coil position to unknown and empties the output stages.
// ----------------------------------------------------------------------------
`default_nettype none

module coil_pulse_switch_driver_top
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_wr_en,
    input  wire logic [cpsd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [cpsd_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic                               op,
    input  wire logic [cpsd_pkg::DEV_W-1:0]         device_index,
    input  wire logic                               coil_select,
    input  wire logic                               activate,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic [cpsd_pkg::PORT_W-1:0]             coil_outputs,
    output logic                                    activity_pulse
);

    cpsd_pkg::ticks_t  hold_reg      [cpsd_pkg::NUM_DEVICES];
    logic              always_fire_reg;
    logic              board_mode_reg;

    cpsd_pkg::pos_t    pos_reg       [cpsd_pkg::NUM_DEVICES];
    cpsd_pkg::pos_t    pos_next      [cpsd_pkg::NUM_DEVICES];
    cpsd_pkg::ticks_t  remain_reg    [cpsd_pkg::NUM_DEVICES];
    cpsd_pkg::ticks_t  remain_next   [cpsd_pkg::NUM_DEVICES];
    cpsd_pkg::port_t   image_reg;
    cpsd_pkg::port_t   image_next;

    cpsd_pkg::result_t res_next;
    cpsd_pkg::result_t out_reg;
    cpsd_pkg::result_t skid_reg;
    logic              out_valid_reg;
    logic              skid_valid_reg;

    logic              in_fire;
    logic              out_fire;
    logic              fire_cmd;
    cpsd_pkg::port_t   clear_mask;

    assign in_stall       = skid_valid_reg;
    assign in_fire        = in_valid && !skid_valid_reg;
    assign out_fire       = out_valid_reg && !out_stall;
    assign out_valid      = out_valid_reg;
    assign coil_outputs   = out_reg.coil_outputs;
    assign activity_pulse = out_reg.activity_pulse;

    assign fire_cmd = (op == cpsd_pkg::OP_CMD) && activate
                      && (int'(device_index) < cpsd_pkg::NUM_DEVICES)
                      && ((pos_reg[device_index] != {1'b0, coil_select}) || always_fire_reg);

    // item evaluation
    always_comb
    begin
        image_next = image_reg;
        clear_mask = '0;
        for (int i = 0; i < cpsd_pkg::NUM_DEVICES; i++)
        begin
            pos_next[i]    = pos_reg[i];
            remain_next[i] = remain_reg[i];
        end
        if (op == cpsd_pkg::OP_TICK)
        begin
            for (int i = 0; i < cpsd_pkg::NUM_DEVICES; i++)
            begin
                if (remain_reg[i] != '0)
                begin
                    remain_next[i] = remain_reg[i] - 1'b1;
                    if (remain_reg[i] == cpsd_pkg::ticks_t'(1))
                    begin
                        clear_mask = clear_mask
                                     | cpsd_pkg::pair_mask(board_mode_reg,
                                                           cpsd_pkg::DEV_W'(i));
                    end
                end
            end
            image_next = image_reg & ~clear_mask;
        end
        else if (fire_cmd)
        begin
            pos_next[device_index]    = {1'b0, coil_select};
            remain_next[device_index] = hold_reg[device_index];
            image_next = (image_reg & ~cpsd_pkg::pair_mask(board_mode_reg, device_index))
                         | cpsd_pkg::coil_bit(board_mode_reg, device_index, coil_select);
        end
        res_next.coil_outputs   = image_next;
        res_next.activity_pulse = fire_cmd;
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < cpsd_pkg::NUM_DEVICES; i++)
            begin
                hold_reg[i] <= '0;
            end
            always_fire_reg <= 1'b0;
            board_mode_reg  <= cpsd_pkg::MODE_SWITCH;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index) inside
                cpsd_pkg::REG_HOLD0, cpsd_pkg::REG_HOLD1,
                cpsd_pkg::REG_HOLD2, cpsd_pkg::REG_HOLD3:
                begin
                    if (int'(cfg_index) < cpsd_pkg::NUM_DEVICES)
                    begin
                        hold_reg[cfg_index[cpsd_pkg::DEV_W-1:0]] <= cfg_data;
                    end
                end
                cpsd_pkg::REG_ALWAYS_FIRE:
                begin
                    always_fire_reg <= cfg_data[0];
                end
                cpsd_pkg::REG_BOARD_MODE:
                begin
                    board_mode_reg <= cfg_data[0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // device state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < cpsd_pkg::NUM_DEVICES; i++)
            begin
                pos_reg[i]    <= cpsd_pkg::POS_UNKNOWN;
                remain_reg[i] <= '0;
            end
            image_reg <= '0;
        end
        else if (in_fire)
        begin
            for (int i = 0; i < cpsd_pkg::NUM_DEVICES; i++)
            begin
                pos_reg[i]    <= pos_next[i];
                remain_reg[i] <= remain_next[i];
            end
            image_reg <= image_next;
        end
    end

    // output register and skid stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            if (!out_valid_reg || out_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else
            begin
                skid_valid_reg <= 1'b1;
            end
        end
        else if (out_fire)
        begin
            out_valid_reg  <= skid_valid_reg;
            skid_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            if (!out_valid_reg || out_fire)
            begin
                out_reg <= res_next;
            end
            else
            begin
                skid_reg <= res_next;
            end
        end
        else if (out_fire && skid_valid_reg)
        begin
            out_reg <= skid_reg;
        end
    end

endmodule

`default_nettype wire

### design/cpsd_checker.sv
// ----------------------------------------------------------------------------
// cpsd_checker
// port-level checks of the coil pulse driver, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module cpsd_checker
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    input  wire logic                               in_stall,
    input  wire logic                               out_valid,
    input  wire logic                               out_stall,
    input  wire logic [cpsd_pkg::PORT_W-1:0]        coil_outputs,
    input  wire logic                               activity_pulse
);

    // held result stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(coil_outputs) && $stable(activity_pulse))
    else $error("stalled result changed");

    // input back-pressure only after the output side stalled with a transfer pending
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(in_stall) |-> $past(out_valid && out_stall && in_valid))
    else $error("input stalled without output back-pressure");

    // an empty output stage shows the result in the cycle after the transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && !out_valid |=> out_valid)
    else $error("result missing one cycle after transfer");

    // a fired coil always leaves its bit set
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && activity_pulse |-> coil_outputs != '0)
    else $error("fired command with empty port image");

endmodule

bind coil_pulse_switch_driver_top cpsd_checker u_cpsd_checker
(
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .coil_outputs   (coil_outputs),
    .activity_pulse (activity_pulse)
);

`default_nettype wire

### verif/coil_driver_checker.sv
// ----------------------------------------------------------------------------
// coil_driver_checker
// tracks the register writes, predicts the port image and activity pulse of
// every input transfer and compares each output transfer, field by field,
// with the oldest prediction
// ----------------------------------------------------------------------------
module coil_driver_checker
    import cpsd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    input  logic                   in_stall,
    input  logic                   op,
    input  logic [DEV_W-1:0]       device_index,
    input  logic                   coil_select,
    input  logic                   activate,
    input  logic                   out_valid,
    input  logic                   out_stall,
    input  logic [PORT_W-1:0]      coil_outputs,
    input  logic                   activity_pulse,
    output int                     fail_count,
    output int                     pending
);
    timeunit 1ns;
    timeprecision 1ps;

    ticks_t  hold_ticks [NUM_DEVICES];
    logic    fire_always;
    logic    board_mode;
    pos_t    coil_pos [NUM_DEVICES];
    ticks_t  countdown [NUM_DEVICES];
    port_t   port_img;
    result_t expected_port_q [$];

    function automatic port_t dev_pair_bits(input int dev);
        port_t m;
        int    lo;
        m = '0;
        if (board_mode == MODE_RELAY)
        begin
            lo = 2 * dev;
        end
        else
        begin
            lo = PORT_W - 2 - 2 * dev;
        end
        m[lo]     = 1'b1;
        m[lo + 1] = 1'b1;
        return m;
    endfunction

    function automatic port_t coil_pin(input int dev, input logic gate);
        port_t m;
        m = '0;
        if (board_mode == MODE_RELAY)
        begin
            m[2 * dev + 1 - int'(gate)] = 1'b1;
        end
        else
        begin
            m[PORT_W - 1 - 2 * dev - int'(gate)] = 1'b1;
        end
        return m;
    endfunction

    function automatic result_t step_coil_image(input logic item_op,
                                                input logic [DEV_W-1:0] dev,
                                                input logic gate, input logic act);
        result_t r;
        logic    fired;
        int      d;
        fired = 1'b0;
        d     = int'(dev);
        if (item_op == OP_CMD)
        begin
            if (act && d < NUM_DEVICES &&
                (coil_pos[d] != {1'b0, gate} || fire_always))
            begin
                port_img     = port_img & ~dev_pair_bits(d);
                coil_pos[d]  = {1'b0, gate};
                countdown[d] = hold_ticks[d];
                port_img     = port_img | coil_pin(d, gate);
                fired        = 1'b1;
            end
        end
        else
        begin
            for (int i = 0; i < NUM_DEVICES; i++)
            begin
                if (countdown[i] != '0)
                begin
                    countdown[i] = countdown[i] - 1'b1;
                    if (countdown[i] == '0)
                    begin
                        port_img = port_img & ~dev_pair_bits(i);
                    end
                end
            end
        end
        r.coil_outputs   = port_img;
        r.activity_pulse = fired;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : monitor
        result_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_DEVICES; i++)
            begin
                hold_ticks[i] = '0;
                coil_pos[i]   = POS_UNKNOWN;
                countdown[i]  = '0;
            end
            fire_always = 1'b0;
            board_mode  = MODE_SWITCH;
            port_img    = '0;
            expected_port_q.delete();
            pending    = 0;
            fail_count = 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_HOLD0:       hold_ticks[0] = cfg_data;
                    REG_HOLD1:       hold_ticks[1] = cfg_data;
                    REG_HOLD2:       hold_ticks[2] = cfg_data;
                    REG_HOLD3:       hold_ticks[3] = cfg_data;
                    REG_ALWAYS_FIRE: fire_always   = cfg_data[0];
                    REG_BOARD_MODE:  board_mode    = cfg_data[0];
                    default: ;
                endcase
            end
            if (out_valid && !out_stall)
            begin
                if (expected_port_q.size() == 0)
                begin
                    $error("unexpected output transfer: coil_outputs %h activity_pulse %b",
                           coil_outputs, activity_pulse);
                    fail_count++;
                end
                else
                begin
                    want = expected_port_q.pop_front();
                    if (coil_outputs !== want.coil_outputs)
                    begin
                        $error("coil_outputs mismatch: expected %h, actual %h",
                               want.coil_outputs, coil_outputs);
                        fail_count++;
                    end
                    if (activity_pulse !== want.activity_pulse)
                    begin
                        $error("activity_pulse mismatch: expected %b, actual %b",
                               want.activity_pulse, activity_pulse);
                        fail_count++;
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                expected_port_q.push_back(step_coil_image(op, device_index,
                                                          coil_select, activate));
            end
            pending = expected_port_q.size();
        end
    end

endmodule

### verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// drives commands and ticks into the coil pulse driver with random gaps and
// output stalls, rewrites the hold times and mode bits between phases, and
// reports the verdict from the checker's failure and pending counts
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import cpsd_pkg::*;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_wr_en;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   in_valid;
    logic                   in_stall;
    logic                   op;
    logic [DEV_W-1:0]       device_index;
    logic                   coil_select;
    logic                   activate;
    logic                   out_valid;
    logic                   out_stall;
    logic [PORT_W-1:0]      coil_outputs;
    logic                   activity_pulse;
    int                     fail_count;
    int                     pending;

    bit send_quiet;
    bit recv_quiet;
    bit long_hold_req;

    coil_pulse_switch_driver_top DUT
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .op             (op),
        .device_index   (device_index),
        .coil_select    (coil_select),
        .activate       (activate),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .coil_outputs   (coil_outputs),
        .activity_pulse (activity_pulse)
    );

    coil_driver_checker u_checker
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .op             (op),
        .device_index   (device_index),
        .coil_select    (coil_select),
        .activate       (activate),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .coil_outputs   (coil_outputs),
        .activity_pulse (activity_pulse),
        .fail_count     (fail_count),
        .pending        (pending)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #6 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // receiver: random stall before each result, long hold-off while requested
    initial
    begin : receiver
        int n;
        out_stall = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (long_hold_req)
            begin
                out_stall <= 1'b1;
                repeat (40) @(negedge clk);
            end
            else
            begin
                n = recv_quiet ? 0 : $urandom_range(0, 10);
                if (n > 0)
                begin
                    out_stall <= 1'b1;
                    repeat (n) @(negedge clk);
                end
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    task automatic send_item(input logic o, input logic [DEV_W-1:0] dev,
                             input logic gate, input logic act);
        int gap;
        gap = send_quiet ? 0 : $urandom_range(0, 10);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid     <= 1'b1;
        op           <= o;
        device_index <= dev;
        coil_select  <= gate;
        activate     <= act;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic send_random_item();
        logic o;
        o = ($urandom_range(0, 9) < 4) ? OP_TICK : OP_CMD;
        send_item(o, DEV_W'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                  ($urandom_range(0, 4) != 0));
    endtask

    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic write_all(input logic [CFG_DATA_W-1:0] h0, input logic [CFG_DATA_W-1:0] h1,
                             input logic [CFG_DATA_W-1:0] h2, input logic [CFG_DATA_W-1:0] h3,
                             input logic af, input logic mode);
        write_reg(REG_HOLD0, h0);
        write_reg(REG_HOLD1, h1);
        write_reg(REG_HOLD2, h2);
        write_reg(REG_HOLD3, h3);
        write_reg(REG_ALWAYS_FIRE, {7'd0, af});
        write_reg(REG_BOARD_MODE, {7'd0, mode});
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_hold();
        if ($urandom_range(0, 3) == 0)
        begin
            return CFG_DATA_W'($urandom_range(0, 255));
        end
        return CFG_DATA_W'($urandom_range(0, 8));
    endfunction

    initial
    begin : stimulus
        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        in_valid      = 1'b0;
        op            = OP_CMD;
        device_index  = '0;
        coil_select   = 1'b0;
        activate      = 1'b0;
        send_quiet    = 1'b0;
        recv_quiet    = 1'b0;
        long_hold_req = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset settings: zero hold keeps the coil on, repeat and deactivate do nothing
        send_item(OP_CMD, 2'd0, 1'b0, 1'b1);
        send_item(OP_CMD, 2'd0, 1'b0, 1'b1);
        send_item(OP_CMD, 2'd0, 1'b1, 1'b0);
        send_item(OP_TICK, 2'd0, 1'b0, 1'b0);
        wait_idle();

        write_all(8'd1, 8'd255, 8'd3, 8'd0, 1'b1, MODE_SWITCH);
        send_item(OP_CMD, 2'd0, 1'b0, 1'b1);
        send_item(OP_CMD, 2'd1, 1'b1, 1'b1);
        send_item(OP_CMD, 2'd2, 1'b0, 1'b1);
        send_item(OP_CMD, 2'd3, 1'b1, 1'b1);
        send_item(OP_TICK, 2'd3, 1'b1, 1'b1);
        send_item(OP_TICK, 2'd1, 1'b0, 1'b0);
        wait_idle();

        // mode change while the device two pulse still runs
        write_reg(REG_BOARD_MODE, {7'd0, MODE_RELAY});
        send_item(OP_TICK, 2'd2, 1'b1, 1'b0);
        send_item(OP_CMD, 2'd3, 1'b0, 1'b1);
        send_item(OP_CMD, 2'd1, 1'b0, 1'b1);
        send_item(OP_TICK, 2'd0, 1'b0, 1'b1);
        wait_idle();

        write_reg(REG_ALWAYS_FIRE, 8'd0);
        send_item(OP_CMD, 2'd1, 1'b0, 1'b1);
        send_item(OP_CMD, 2'd2, 1'b1, 1'b1);
        send_item(OP_CMD, 2'd2, 1'b1, 1'b0);
        wait_idle();

        for (int phase = 0; phase < 6; phase++)
        begin
            if (phase == 0)
            begin
                write_all(8'd0, 8'd0, 8'd0, 8'd0, 1'b0, MODE_SWITCH);
            end
            else if (phase == 1)
            begin
                write_all(8'd255, 8'd255, 8'd255, 8'd255, 1'b1, MODE_RELAY);
            end
            else
            begin
                write_all(pick_hold(), pick_hold(), pick_hold(), pick_hold(),
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end
            for (int k = 0; k < 300; k++)
            begin
                if (k % 50 == 0)
                begin
                    send_quiet = ($urandom_range(0, 2) == 0);
                    recv_quiet = ($urandom_range(0, 2) == 0);
                end
                if (phase == 2 && k == 100)
                begin
                    // receiver holds off while transfers keep coming
                    long_hold_req = 1'b1;
                    send_quiet    = 1'b1;
                    repeat (12) send_random_item();
                    send_quiet    = 1'b0;
                    long_hold_req = 1'b0;
                end
                if (phase == 3 && k == 150)
                begin
                    wait_idle();
                end
                send_random_item();
            end
            wait_idle();
        end

        repeat (5) @(posedge clk);
        if (fail_count == 0 && pending == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
